@@ hdl/sha256mh_pkg.sv @@
`default_nettype none

package sha256mh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } sha256mh_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } sha256mh_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } sha256mh_state_t;

    // Control from the sequencer to the compression datapath
    typedef struct packed {
        logic       shift_in;
        logic       rotate;
        logic       round;
        logic       w_prime;
        logic [5:0] rnd;
    } sha256mh_ctrl_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

@@ hdl/sha256mh_ram.sv @@
`default_nettype none

module sha256mh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/sha256mh_core.sv @@
`default_nettype none

module sha256mh_core (
    input  logic                        aclk,
    input  sha256mh_pkg::sha256mh_ctrl_t ctrl,
    input  logic [31:0]                 hash_rd,
    input  logic [31:0]                 msg_rd,
    output logic [31:0]                 upd_word
);
    import sha256mh_pkg::*;

    logic [31:0] wv_reg  [8];
    logic [31:0] win_reg [16];
    logic [31:0] wcur_reg;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sched;
    logic [31:0] ch;
    logic [31:0] maj;

    always_comb begin
        ch    = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
        maj   = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
        t1    = wv_reg[7] + big_sigma1(wv_reg[4]) + ch + ROUND_CONST[ctrl.rnd] + wcur_reg;
        t2    = big_sigma0(wv_reg[0]) + maj;
        // schedule word for the following round
        sched = small_sigma1(win_reg[15]) + win_reg[10] + small_sigma0(win_reg[2]) + win_reg[1];
    end

    assign upd_word = hash_rd + wv_reg[0];

    always_ff @(posedge aclk) begin
        if (ctrl.round) begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= wcur_reg;
            wcur_reg    <= (ctrl.rnd < 6'd15) ? msg_rd : sched;
        end else if (ctrl.shift_in || ctrl.rotate) begin
            for (int i = 0; i < 7; i++) begin
                wv_reg[i] <= wv_reg[i+1];
            end
            wv_reg[7] <= ctrl.shift_in ? hash_rd : wv_reg[0];
        end
        if (ctrl.w_prime) begin
            wcur_reg <= msg_rd;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sha256_message_hash.sv @@
// Bytes are accepted one per cycle, only while idle. A full block then compresses in hash load,
// 64 rounds and write back; load and write back move one hash word per cycle.
// Final request: pad states close the block, one or two blocks compress, the second after more pad
// states, then the eight digest words go out, each through the read, load and wait states.
// Reset clears the sequencer and byte count and marks the hash memory as holding the initial
// values; the message buffer is undefined.
`default_nettype none

module sha256_message_hash (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sha256mh_pkg::sha256mh_in_t   s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output sha256mh_pkg::sha256mh_out_t  m_data
);
    import sha256mh_pkg::*;

    sha256mh_state_t state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    logic [60:0] count_reg, count_next;
    logic [23:0] word_reg, word_next;
    logic        fin_reg, fin_next;
    logic        pass1_reg, pass1_next;
    logic        pad_done_reg, pad_done_next;
    logic        hash_iv_reg, hash_iv_next;
    logic        m_valid_reg, m_valid_next;
    sha256mh_out_t m_data_reg, m_data_next;
    logic [2:0]  hrd_idx_reg;

    // memory ports
    logic        mwe;
    logic [3:0]  mwaddr;
    logic [31:0] mwdata;
    logic [3:0]  mraddr;
    logic [31:0] msg_rd;
    logic        hwe;
    logic [2:0]  hwaddr;
    logic [31:0] hwdata;
    logic [2:0]  hraddr;
    logic [31:0] hram_rd;
    logic [31:0] hash_rd;

    sha256mh_ctrl_t ctrl;
    logic [31:0]    upd_word;

    logic        in_acc;
    logic [60:0] count_inc;
    logic [5:0]  pos_new;
    logic [31:0] partial_word;
    logic [63:0] bit_len;
    logic        wrap;
    logic        len_en;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign in_acc  = s_valid && s_ready;

    assign count_inc = count_reg + 61'd1;
    assign pos_new   = s_data.byte_valid ? count_inc[5:0] : count_reg[5:0];
    assign bit_len   = {count_reg, 3'b000};
    // pad word lands in the last two words: length goes into a second block
    assign wrap      = (count_reg[5:3] == 3'b111);
    assign len_en    = !(pass1_reg && wrap);

    // hash memory reads as the initial values until the first write back
    assign hash_rd = hash_iv_reg ? INIT_HASH[hrd_idx_reg] : hram_rd;

    // close the partial word with the 0x80 marker
    always_comb begin
        case (count_reg[1:0])
            2'd0:    partial_word = 32'h8000_0000;
            2'd1:    partial_word = {word_reg[7:0], 8'h80, 16'h0000};
            2'd2:    partial_word = {word_reg[15:0], 8'h80, 8'h00};
            default: partial_word = {word_reg[23:0], 8'h80};
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rnd_next      = rnd_reg;
        pad_idx_next  = pad_idx_reg;
        out_idx_next  = out_idx_reg;
        count_next    = count_reg;
        word_next     = word_reg;
        fin_next      = fin_reg;
        pass1_next    = pass1_reg;
        pad_done_next = pad_done_reg;
        hash_iv_next  = hash_iv_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mwe           = 1'b0;
        mwaddr        = '0;
        mwdata        = '0;
        mraddr        = '0;
        hwe           = 1'b0;
        hwaddr        = '0;
        hwdata        = upd_word;
        hraddr        = '0;
        ctrl          = '0;
        ctrl.rnd      = rnd_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_data.byte_valid) begin
                        count_next = count_inc;
                        word_next  = {word_reg[15:0], s_data.data_byte};
                        if (count_reg[1:0] == 2'd3) begin
                            mwe    = 1'b1;
                            mwaddr = count_reg[5:2];
                            mwdata = {word_reg, s_data.data_byte};
                        end
                    end
                    if (s_data.end_of_message) begin
                        fin_next      = 1'b1;
                        pass1_next    = 1'b1;
                        pad_done_next = 1'b0;
                    end
                    if (s_data.byte_valid && count_reg[5:0] == 6'd63) begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end else if (s_data.end_of_message) begin
                        state_next   = ST_PAD;
                        pad_idx_next = pos_new[5:2];
                    end
                end
            end

            ST_PAD: begin
                mwe    = 1'b1;
                mwaddr = pad_idx_reg;
                if (pass1_reg && pad_idx_reg == count_reg[5:2]) begin
                    mwdata = partial_word;
                end else if (len_en && pad_idx_reg == 4'd14) begin
                    mwdata = bit_len[63:32];
                end else if (len_en && pad_idx_reg == 4'd15) begin
                    mwdata = bit_len[31:0];
                end
                if (pad_idx_reg == 4'd15) begin
                    pass1_next    = 1'b0;
                    pad_done_next = len_en;
                    state_next    = ST_LOAD;
                    cnt_next      = '0;
                end else begin
                    pad_idx_next = pad_idx_reg + 4'd1;
                end
            end

            ST_LOAD: begin
                hraddr        = cnt_reg[2:0];
                ctrl.shift_in = (cnt_reg != 4'd0);
                if (cnt_reg == 4'd8) begin
                    ctrl.w_prime = 1'b1;
                    mraddr       = 4'd1;
                    state_next   = ST_ROUND;
                    rnd_next     = '0;
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end

            ST_ROUND: begin
                ctrl.round = 1'b1;
                // prefetch two rounds ahead for the registered schedule word
                mraddr     = rnd_reg[3:0] + 4'd2;
                if (rnd_reg == 6'd63) begin
                    state_next = ST_UPDATE;
                    cnt_next   = '0;
                end else begin
                    rnd_next = rnd_reg + 6'd1;
                end
            end

            ST_UPDATE: begin
                hraddr = cnt_reg[2:0];
                if (cnt_reg != 4'd0) begin
                    hwe         = 1'b1;
                    hwaddr      = cnt_reg[2:0] - 3'd1;
                    ctrl.rotate = 1'b1;
                end
                if (cnt_reg == 4'd8) begin
                    hash_iv_next = 1'b0;
                    if (!fin_reg) begin
                        state_next = ST_IDLE;
                    end else if (pad_done_reg) begin
                        state_next   = ST_OUT_RD;
                        out_idx_next = '0;
                    end else begin
                        state_next   = ST_PAD;
                        pad_idx_next = '0;
                    end
                end else begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end

            ST_OUT_RD: begin
                hraddr     = out_idx_reg;
                state_next = ST_OUT_LD;
            end

            ST_OUT_LD: begin
                m_valid_next            = 1'b1;
                m_data_next.digest_word = hash_rd;
                m_data_next.word_number = out_idx_reg;
                m_data_next.last_word   = (out_idx_reg == 3'd7);
                state_next              = ST_OUT_WAIT;
            end

            ST_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (out_idx_reg == 3'd7) begin
                        state_next    = ST_IDLE;
                        count_next    = '0;
                        fin_next      = 1'b0;
                        pad_done_next = 1'b0;
                        hash_iv_next  = 1'b1;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                        state_next   = ST_OUT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rnd_reg      <= '0;
            pad_idx_reg  <= '0;
            out_idx_reg  <= '0;
            count_reg    <= '0;
            fin_reg      <= 1'b0;
            pass1_reg    <= 1'b0;
            pad_done_reg <= 1'b0;
            hash_iv_reg  <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rnd_reg      <= rnd_next;
            pad_idx_reg  <= pad_idx_next;
            out_idx_reg  <= out_idx_next;
            count_reg    <= count_next;
            fin_reg      <= fin_next;
            pass1_reg    <= pass1_next;
            pad_done_reg <= pad_done_next;
            hash_iv_reg  <= hash_iv_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        word_reg    <= word_next;
        m_data_reg  <= m_data_next;
        hrd_idx_reg <= hraddr;
    end

    // message block buffer: one word per four bytes, then padding
    sha256mh_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_msg_ram (
        .clk   (aclk),
        .we    (mwe),
        .waddr (mwaddr),
        .wdata (mwdata),
        .raddr (mraddr),
        .rdata (msg_rd)
    );

    // running hash words; write back trails the read by one entry
    sha256mh_ram #(
        .WIDTH (32),
        .DEPTH (8)
    ) u_hash_ram (
        .clk   (aclk),
        .we    (hwe),
        .waddr (hwaddr),
        .wdata (hwdata),
        .raddr (hraddr),
        .rdata (hram_rd)
    );

    sha256mh_core u_core (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .hash_rd  (hash_rd),
        .msg_rd   (msg_rd),
        .upd_word (upd_word)
    );

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while digest pending");

    a_hash_write: assert property (@(posedge aclk) disable iff (!aresetn)
        hwe |-> (state_reg == ST_UPDATE && hrd_idx_reg == hwaddr))
        else $error("hash write outside write back or misaligned");

    a_msg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        mwe |-> (state_reg == ST_IDLE || state_reg == ST_PAD))
        else $error("message buffer written during compression");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_word) |=>
            (state_reg == ST_IDLE && hash_iv_reg && count_reg == 61'd0))
        else $error("state not restored after digest");

    a_word_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.word_number == out_idx_reg))
        else $error("digest word position mismatch");
`endif

endmodule

`default_nettype wire
